[hw/rtl/wspd_pkg.sv]
// ----------------------------------------------------------------------------
// wspd_pkg
// Shared constants and helpers for the weather sensor packet decoder.
// ----------------------------------------------------------------------------
package wspd_pkg;

    // longest packet whose checksum can pass
    localparam int MaxLen = 16;

    // width of the byte position counter, saturating at its top value
    localparam int PosW = 7;
    localparam logic [PosW-1:0] PosMax = '1;

    // packet byte positions
    localparam logic [PosW-1:0] PosType0 = 7'd0;
    localparam logic [PosW-1:0] PosType1 = 7'd1;
    localparam logic [PosW-1:0] PosId    = 7'd4;
    localparam logic [PosW-1:0] PosTemp  = 7'd5;
    localparam logic [PosW-1:0] PosSign  = 7'd6;
    localparam logic [PosW-1:0] PosHumid = 7'd7;
    localparam logic [PosW-1:0] PosCheck = 7'd8;
    localparam logic [PosW-1:0] PosLimit = PosW'(MaxLen);

    // number of stored field bytes (id .. check byte)
    localparam int FieldCnt = 5;

    // checksum offset
    localparam logic [10:0] SumOffset = 11'd10;

    // battery good threshold on the low nibble of the id byte
    localparam logic [3:0] BattThresh = 4'd4;

    // sign threshold on the low nibble of byte 6
    localparam logic [3:0] SignThresh = 4'd8;

    // known sensor type codes, byte 0 then byte 1
    localparam logic [7:0] TypeA0 = 8'h1A;
    localparam logic [7:0] TypeA1 = 8'h3D;
    localparam logic [7:0] TypeB0 = 8'h3A;
    localparam logic [7:0] TypeB1 = 8'h0D;
    localparam logic [7:0] TypeC0 = 8'hF8;
    localparam logic [7:0] TypeC1 = 8'h24;
    localparam logic [7:0] TypeD0 = 8'h1D;
    localparam logic [7:0] TypeD1 = 8'h20;

    // result tdata width, rounded up to whole bytes
    localparam int ResW  = 1 + 1 + 12 + 8 + 1 + 8;
    localparam int MDataW = ((ResW + 7) / 8) * 8;

    typedef logic [7:0] byte_t;

    // header lookup over the four type codes
    function automatic logic type_code_match(input byte_t b0, input byte_t b1);
        type_code_match = (b0 == TypeA0 && b1 == TypeA1) ||
                          (b0 == TypeB0 && b1 == TypeB1) ||
                          (b0 == TypeC0 && b1 == TypeC1) ||
                          (b0 == TypeD0 && b1 == TypeD1);
    endfunction

endpackage

[hw/rtl/weather_sensor_packet_decoder.sv]
// ----------------------------------------------------------------------------
// weather_sensor_packet_decoder
// Byte-wise decoder for radio weather sensor packets: header check,
// nibble checksum and BCD field decode, one result per packet.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)                          tlast
//  s_        in   data_byte[7:0]                              last byte of packet
//  m_        out  header_match, checksum_ok,                  -
//                 temperature_tenths[11:0], humidity[7:0],
//                 battery_ok, sensor_id[7:0], zero pad
//
//  one byte is taken per cycle while no last byte waits on a stalled result;
//  a byte passes an input register, then updates the packet state and, if
//  it is a last byte, the result register; m_tvalid rises when the last
//  byte leaves the input register and the result register is free
//  aresetn (synchronous) clears the packet counters and both valid flags
//  a stalled result only holds back a following last byte; other bytes flow
//
module weather_sensor_packet_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // data_byte[7:0]
    input  logic                        s_tlast,   // last
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // header_match[0], checksum_ok[1], temperature_tenths[13:2],
    // humidity[21:14], battery_ok[22], sensor_id[30:23], zero[31]
    output logic [wspd_pkg::MDataW-1:0] m_tdata
);

    // input register
    logic                  in_valid_reg, in_valid_next;
    wspd_pkg::byte_t       in_byte_reg;
    logic                  in_last_reg;

    // packet state
    logic [wspd_pkg::PosW-1:0] pos_reg, pos_next;
    logic [10:0]               sum_reg, sum_next;
    wspd_pkg::byte_t           first_reg, first_next;
    logic                      hdr_reg, hdr_next;
    logic                      cbs_reg, cbs_next;
    wspd_pkg::byte_t           field_reg [wspd_pkg::FieldCnt];

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [wspd_pkg::MDataW-1:0] out_data_reg, out_data_next;

    logic advance;

    // stage advance: only a last byte waits on a full result register
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    // current field bytes, with the byte in flight forwarded
    wspd_pkg::byte_t b4, b5, b6, b7, b8;
    assign b4 = (pos_reg == wspd_pkg::PosId)    ? in_byte_reg : field_reg[0];
    assign b5 = (pos_reg == wspd_pkg::PosTemp)  ? in_byte_reg : field_reg[1];
    assign b6 = (pos_reg == wspd_pkg::PosSign)  ? in_byte_reg : field_reg[2];
    assign b7 = (pos_reg == wspd_pkg::PosHumid) ? in_byte_reg : field_reg[3];
    assign b8 = (pos_reg == wspd_pkg::PosCheck) ? in_byte_reg : field_reg[4];

    // packet state update
    always_comb begin
        first_next = first_reg;
        hdr_next   = hdr_reg;
        cbs_next   = cbs_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        if (pos_reg == wspd_pkg::PosType0) begin
            first_next = in_byte_reg;
            hdr_next   = 1'b0;
        end else if (pos_reg == wspd_pkg::PosType1) begin
            hdr_next = wspd_pkg::type_code_match(first_reg, in_byte_reg);
        end
        if (pos_reg == wspd_pkg::PosCheck) begin
            cbs_next = 1'b1;
        end
        if (!in_last_reg) begin
            if (pos_reg < wspd_pkg::PosLimit) begin
                sum_next = sum_reg + 11'(in_byte_reg[7:4]) + 11'(in_byte_reg[3:0]);
            end
            if (pos_reg != wspd_pkg::PosMax) begin
                pos_next = pos_reg + 1'b1;
            end
        end else begin
            pos_next = '0;
            sum_next = '0;
            cbs_next = 1'b0;
        end
    end

    // field decode for the result
    logic [10:0]        mag;
    logic signed [11:0] temp;
    logic [7:0]         humid;
    logic               cksum_ok;
    logic               hdr_out;

    always_comb begin
        mag   = 11'(b5[7:4]) * 11'd100 + 11'(b5[3:0]) * 11'd10 + 11'(b4[7:4]);
        temp  = (b6[3:0] >= wspd_pkg::SignThresh) ? -$signed({1'b0, mag})
                                                  : $signed({1'b0, mag});
        humid = 8'(b7[3:0] * 8'd10) + 8'(b6[7:4]);
        // check byte seen earlier in this packet or arriving now
        cksum_ok = (cbs_reg || (pos_reg == wspd_pkg::PosCheck)) &&
                   (pos_reg >= wspd_pkg::PosCheck) &&
                   (pos_reg < wspd_pkg::PosLimit) &&
                   (sum_reg == 11'(b8) + wspd_pkg::SumOffset);
        hdr_out = (pos_reg != wspd_pkg::PosType0) && hdr_next;
        out_data_next = {1'b0, b4, (b4[3:0] >= wspd_pkg::BattThresh), humid,
                         temp, cksum_ok, hdr_out};
    end

    // result valid
    always_comb begin
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            first_reg     <= '0;
            hdr_reg       <= 1'b0;
            cbs_reg       <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                first_reg <= first_next;
                hdr_reg   <= hdr_next;
                cbs_reg   <= cbs_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            field_reg[0] <= b4;
            field_reg[1] <= b5;
            field_reg[2] <= b6;
            field_reg[3] <= b7;
            field_reg[4] <= b8;
        end
        if (advance && in_last_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a packet end restarts the byte count and sum
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (pos_reg == '0 && sum_reg == '0 && !cbs_reg))
        else $error("packet state not cleared after last byte");

    // a packet end always loads a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> m_tvalid)
        else $error("last byte did not produce a result");

    // a mid-packet byte never creates a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !(advance && in_last_reg)) |=> !m_tvalid)
        else $error("result appeared without a last byte");

    // checksum cannot pass on a packet too short to hold the check byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg && pos_reg < wspd_pkg::PosCheck) |=> !m_tdata[1])
        else $error("checksum passed on short packet");

endmodule

[dv/weather_sensor_packet_decoder_tb.sv]
// ----------------------------------------------------------------------------
// weather_sensor_packet_decoder_tb
// Self-checking bench for the sensor packet decoder: a short table of
// hand-built packets, then random packets (mostly well-formed with a correct
// checksum, plus short, long, saturating and noise packets) under three
// back-pressure mixes. Every result is checked field by field, for typed
// table rows against the table, else against a bench byte-level decoder model.
// ----------------------------------------------------------------------------
module weather_sensor_packet_decoder_tb;

    // one decoded sensor reading, header_match in bit 0 as on m_tdata
    typedef struct packed {
        logic [7:0]         sensor_id;
        logic               battery_ok;
        logic [7:0]         humidity;
        logic signed [11:0] temperature_tenths;
        logic               checksum_ok;
        logic               header_match;
    } reading_t;

    // hand-built packet, first byte in the highest used byte of pkt
    typedef struct packed {
        logic [7:0]   len;
        logic [135:0] pkt;
        logic         typed;
        reading_t     want;
    } dir_row_t;

    localparam int DirRows       = 8;
    localparam int BytesPerPhase = 330;
    localparam int StallLimit    = 2000;
    localparam int PktMax        = 140;
    localparam int SparePos      = 3;     // byte with no decoded field
    localparam int PadW          = wspd_pkg::MDataW - $bits(reading_t);

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata  = '0;
    logic                        s_tlast  = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [wspd_pkg::MDataW-1:0] m_tdata;

    int unsigned send_idle_pct = 11;
    int unsigned recv_idle_pct = 80;
    int unsigned idle_cycles   = 0;
    bit          mismatch_seen = 1'b0;

    wspd_pkg::byte_t pkt_buf [PktMax];
    reading_t        readings_due [$];

    // decoder model state
    logic [wspd_pkg::PosW-1:0] dec_pos   = '0;
    logic [10:0]               dec_sum   = '0;
    wspd_pkg::byte_t           dec_first = '0;
    logic                      dec_hdr   = 1'b0;
    logic                      dec_chk   = 1'b0;
    wspd_pkg::byte_t           dec_fields [wspd_pkg::FieldCnt];

    // directed packets: valid, extremes, one byte, small sum, short, two byte,
    // swapped header, ten bytes with the check byte inside the sum
    dir_row_t dir_table [DirRows] = '{
        '{8'd9,  136'h1A3D10054723510431,   1'b1,
          '{8'h47, 1'b1, 8'd45, 12'sd234, 1'b1, 1'b1}},
        '{8'd9,  136'hF8240000F3FFF80F69,   1'b1,
          '{8'hF3, 1'b0, 8'd165, -12'sd1665, 1'b1, 1'b1}},
        '{8'd1,  136'hFF,                   1'b0, '0},
        '{8'd9,  136'h0000000000000000F6,   1'b1,
          '{8'h00, 1'b0, 8'd0, 12'sd0, 1'b0, 1'b0}},
        '{8'd5,  136'h1D20112233,           1'b0, '0},
        '{8'd2,  136'h1A3D,                 1'b0, '0},
        '{8'd9,  136'h3D1A10054723510431,   1'b0, '0},
        '{8'd10, 136'h3A0D00669412090745AB, 1'b1,
          '{8'h94, 1'b1, 8'd70, -12'sd129, 1'b1, 1'b1}}
    };

    always #5 aclk = ~aclk;

    weather_sensor_packet_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic int nib_total(input wspd_pkg::byte_t b);
        return int'(b[7:4]) + int'(b[3:0]);
    endfunction

    // advance the decoder model by one byte, returns 1 when a reading is due
    function automatic bit decode_sensor_byte(input wspd_pkg::byte_t b, input logic fin,
                                              output reading_t r);
        int              mag;
        int              plen;
        wspd_pkg::byte_t f4, f5, f6, f7, f8;
        r = '0;
        if (dec_pos == wspd_pkg::PosType0) begin
            dec_first = b;
            dec_hdr   = 1'b0;
        end else if (dec_pos == wspd_pkg::PosType1) begin
            dec_hdr = wspd_pkg::type_code_match(dec_first, b);
        end
        if (dec_pos >= wspd_pkg::PosId && dec_pos <= wspd_pkg::PosCheck) begin
            dec_fields[3'(dec_pos - wspd_pkg::PosId)] = b;
            if (dec_pos == wspd_pkg::PosCheck)
                dec_chk = 1'b1;
        end
        // only bytes before the last one feed the sum and the counter
        if (!fin) begin
            if (dec_pos < wspd_pkg::PosLimit)
                dec_sum = dec_sum + 11'(nib_total(b));
            if (dec_pos != wspd_pkg::PosMax)
                dec_pos = dec_pos + 1'b1;
            return 1'b0;
        end
        f4   = dec_fields[0];
        f5   = dec_fields[1];
        f6   = dec_fields[2];
        f7   = dec_fields[3];
        f8   = dec_fields[4];
        mag  = int'(f5[7:4]) * 100 + int'(f5[3:0]) * 10 + int'(f4[7:4]);
        plen = int'(dec_pos) + 1;
        r.header_match = (dec_pos != wspd_pkg::PosType0) && dec_hdr;
        r.checksum_ok  = dec_chk && plen >= int'(wspd_pkg::PosCheck) + 1 &&
                         plen <= wspd_pkg::MaxLen && dec_sum >= wspd_pkg::SumOffset &&
                         (dec_sum - wspd_pkg::SumOffset) == 11'(f8);
        r.temperature_tenths = (f6[3:0] >= wspd_pkg::SignThresh) ? 12'(-mag) : 12'(mag);
        r.humidity   = 8'(int'(f7[3:0]) * 10 + int'(f6[7:4]));
        r.battery_ok = (f4[3:0] >= wspd_pkg::BattThresh);
        r.sensor_id  = f4;
        dec_pos = '0;
        dec_sum = '0;
        dec_chk = 1'b0;
        return 1'b1;
    endfunction

    // fill pkt_buf with one random packet, mostly well-formed
    function automatic void build_sensor_packet(output int unsigned n);
        int              kind;
        int              s;
        int              tries;
        int              ofs;
        bit              found;
        wspd_pkg::byte_t start;
        kind = $urandom_range(0, 99);
        ofs  = int'(wspd_pkg::SumOffset);
        if (kind < 70)
            n = ($urandom_range(0, 3) == 0) ?
                $urandom_range(wspd_pkg::PosCheck + 2, wspd_pkg::MaxLen) :
                wspd_pkg::PosCheck + 1;
        else if (kind < 80)
            n = $urandom_range(1, 20);
        else if (kind < 92)
            n = $urandom_range(1, wspd_pkg::PosCheck);
        else if ($urandom_range(0, 3) == 0)
            n = $urandom_range(wspd_pkg::PosMax + 1, PktMax);
        else
            n = $urandom_range(wspd_pkg::MaxLen + 1, 40);
        for (int i = 0; i < n; i++)
            pkt_buf[i] = wspd_pkg::byte_t'($urandom);
        // known type code, except in half of the noise packets
        if (kind < 70 || kind >= 80 || $urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 3))
                0: begin
                    pkt_buf[0] = wspd_pkg::TypeA0;
                    pkt_buf[1] = wspd_pkg::TypeA1;
                end
                1: begin
                    pkt_buf[0] = wspd_pkg::TypeB0;
                    pkt_buf[1] = wspd_pkg::TypeB1;
                end
                2: begin
                    pkt_buf[0] = wspd_pkg::TypeC0;
                    pkt_buf[1] = wspd_pkg::TypeC1;
                end
                default: begin
                    pkt_buf[0] = wspd_pkg::TypeD0;
                    pkt_buf[1] = wspd_pkg::TypeD1;
                end
            endcase
        end
        if (kind < 70) begin
            if (n == wspd_pkg::PosCheck + 1) begin
                // check byte is last and outside the sum
                s = 0;
                for (int i = 0; i < wspd_pkg::PosCheck; i++)
                    s += nib_total(pkt_buf[i]);
                pkt_buf[wspd_pkg::PosCheck] = wspd_pkg::byte_t'(s - ofs);
            end else begin
                // check byte is summed: sum - offset must be 15 times its high nibble
                start = wspd_pkg::byte_t'($urandom);
                found = 1'b0;
                s     = 0;
                for (tries = 0; tries < 256 && !found; tries++) begin
                    pkt_buf[SparePos] = start + wspd_pkg::byte_t'(tries);
                    s = 0;
                    for (int i = 0; i < n - 1; i++)
                        if (i != wspd_pkg::PosCheck)
                            s += nib_total(pkt_buf[i]);
                    found = (s >= ofs) && ((s - ofs) % 15 == 0) && ((s - ofs) / 15 <= 15);
                end
                pkt_buf[wspd_pkg::PosCheck][7:4] = 4'((s - ofs) / 15);
            end
            // some well-formed packets get a corrupted check byte
            if ($urandom_range(0, 4) == 0)
                pkt_buf[wspd_pkg::PosCheck] ^= wspd_pkg::byte_t'(1 << $urandom_range(0, 7));
        end
    endfunction

    // push pkt_buf[0..n-1] through the input channel, one transfer per byte
    task automatic send_packet(input int unsigned n, input bit typed, input reading_t want);
        reading_t r;
        bit       due;
        for (int unsigned i = 0; i < n; i++) begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= pkt_buf[i];
            s_tlast  <= (i == n - 1);
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
            due = decode_sensor_byte(pkt_buf[i], i == n - 1, r);
            if (due)
                readings_due.push_back(typed ? want : r);
        end
    endtask

    task automatic drain_readings();
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic check_reading(input reading_t got, input logic [PadW-1:0] pad);
        reading_t want;
        if (readings_due.size() == 0) begin
            $error("result transfer with nothing expected: %h", got);
            mismatch_seen = 1'b1;
        end else begin
            want = readings_due.pop_front();
            if (got.header_match !== want.header_match) begin
                $error("header_match: expected %0d, got %0d",
                       want.header_match, got.header_match);
                mismatch_seen = 1'b1;
            end
            if (got.checksum_ok !== want.checksum_ok) begin
                $error("checksum_ok: expected %0d, got %0d",
                       want.checksum_ok, got.checksum_ok);
                mismatch_seen = 1'b1;
            end
            if (got.temperature_tenths !== want.temperature_tenths) begin
                $error("temperature_tenths: expected %0d, got %0d",
                       want.temperature_tenths, got.temperature_tenths);
                mismatch_seen = 1'b1;
            end
            if (got.humidity !== want.humidity) begin
                $error("humidity: expected %0d, got %0d", want.humidity, got.humidity);
                mismatch_seen = 1'b1;
            end
            if (got.battery_ok !== want.battery_ok) begin
                $error("battery_ok: expected %0d, got %0d",
                       want.battery_ok, got.battery_ok);
                mismatch_seen = 1'b1;
            end
            if (got.sensor_id !== want.sensor_id) begin
                $error("sensor_id: expected %h, got %h", want.sensor_id, got.sensor_id);
                mismatch_seen = 1'b1;
            end
            if (pad !== '0) begin
                $error("pad: expected 0, got %h", pad);
                mismatch_seen = 1'b1;
            end
        end
    endtask

    // result side: check each transfer, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_reading(reading_t'(m_tdata[$bits(reading_t)-1:0]),
                          m_tdata[wspd_pkg::MDataW-1:$bits(reading_t)]);
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == StallLimit) begin
            $display("weather_sensor_packet_decoder test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned n;
        int unsigned sent;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, the first row writes every stored field byte
        for (int d = 0; d < DirRows; d++) begin
            for (int i = 0; i < dir_table[d].len; i++)
                pkt_buf[i] = dir_table[d].pkt[8 * (dir_table[d].len - 1 - i) +: 8];
            send_packet(dir_table[d].len, dir_table[d].typed, dir_table[d].want);
        end

        // random packets under three back-pressure mixes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 11; recv_idle_pct = 80; end
                1: begin send_idle_pct = 80; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            sent = 0;
            while (sent < BytesPerPhase) begin
                build_sensor_packet(n);
                send_packet(n, 1'b0, '0);
                sent += n;
            end
            drain_readings();
        end

        if (mismatch_seen)
            $display("weather_sensor_packet_decoder test failed");
        else
            $display("weather_sensor_packet_decoder test passed");
        $finish;
    end

endmodule
